// ===== rtl/ldnp_pkg.sv =====
// ----------------------------------------------------------------------------
// ldnp_pkg - shared types and constants of the LCD decimal number printer
// Microcode word layout, datapath flags and the fixed field widths.
// ----------------------------------------------------------------------------
package ldnp_pkg;

  localparam int NUM_W     = 16;
  localparam int ADDR_W    = 7;
  localparam int BYTE_W    = 8;
  localparam int NIB_W     = 4;
  localparam int DIGITS    = 5;
  localparam int DIG_IDX_W = 3;
  localparam int UPC_W     = 4;
  localparam int PROD_W    = 32;

  // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
  localparam logic [NUM_W-1:0] RECIP_10    = 16'hCCCD;
  localparam int               RECIP_SHIFT = 19;
  localparam int               QUO_W       = PROD_W - RECIP_SHIFT;

  localparam logic [ADDR_W-1:0] ADDR_RESET    = 7'd39;
  localparam logic [NIB_W-1:0]  ASCII_DIG_HI  = 4'h3;  // high nibble of '0'..'9'
  localparam logic              BACKLIGHT_ON  = 1'b1;
  localparam logic              RW_WRITE      = 1'b0;
  localparam logic              RS_DATA       = 1'b1;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_START,
    COND_Q_NZ,
    COND_PTR_NZ
  } cond_sel_t;

  // One microcode word: datapath strobes plus a two-way branch
  typedef struct packed {
    logic      load;      // take a new number when start is high
    logic      mul;       // form reciprocal product
    logic      div;       // split off one digit
    logic      emit;      // drive one expander byte
    logic      nib_hi;    // high nibble of the character
    logic      enable;    // LCD enable bit
    logic      last_chk;  // final byte of a character, step digit pointer
    cond_sel_t cond;
    upc_t      tgt;       // taken when cond holds
    upc_t      nxt;       // taken otherwise
  } uword_t;

  typedef struct packed {
    logic start;
    logic q_nz;
    logic ptr_nz;
  } dp_flags_t;

endpackage

// ===== rtl/ldnp_useq.sv =====
// ----------------------------------------------------------------------------
// ldnp_useq - microsequencer
// Step counter, program ROM and conditional branch selection.
// ----------------------------------------------------------------------------
module ldnp_useq (
  input  logic               clk,
  input  logic               rst_n,
  input  ldnp_pkg::dp_flags_t flags,
  output ldnp_pkg::uword_t   uw,
  output logic               busy
);
  import ldnp_pkg::*;

  localparam upc_t UPC_IDLE = 4'd0;
  localparam upc_t UPC_MUL  = 4'd1;
  localparam upc_t UPC_DIV  = 4'd2;
  localparam upc_t UPC_H0   = 4'd3;
  localparam upc_t UPC_H1   = 4'd4;
  localparam upc_t UPC_H2   = 4'd5;
  localparam upc_t UPC_L0   = 4'd6;
  localparam upc_t UPC_L1   = 4'd7;
  localparam upc_t UPC_L2   = 4'd8;

  function automatic uword_t rom_word(input upc_t a);
    uword_t w;
    w = '{load: 1'b0, mul: 1'b0, div: 1'b0, emit: 1'b0, nib_hi: 1'b0,
          enable: 1'b0, last_chk: 1'b0, cond: COND_ALWAYS,
          tgt: UPC_IDLE, nxt: UPC_IDLE};
    unique case (a)
      UPC_IDLE: begin
        w.load = 1'b1; w.cond = COND_START; w.tgt = UPC_MUL; w.nxt = UPC_IDLE;
      end
      UPC_MUL: begin
        w.mul = 1'b1; w.tgt = UPC_DIV; w.nxt = UPC_DIV;
      end
      UPC_DIV: begin
        w.div = 1'b1; w.cond = COND_Q_NZ; w.tgt = UPC_MUL; w.nxt = UPC_H0;
      end
      UPC_H0: begin
        w.emit = 1'b1; w.nib_hi = 1'b1; w.tgt = UPC_H1; w.nxt = UPC_H1;
      end
      UPC_H1: begin
        w.emit = 1'b1; w.nib_hi = 1'b1; w.enable = 1'b1; w.tgt = UPC_H2; w.nxt = UPC_H2;
      end
      UPC_H2: begin
        w.emit = 1'b1; w.nib_hi = 1'b1; w.tgt = UPC_L0; w.nxt = UPC_L0;
      end
      UPC_L0: begin
        w.emit = 1'b1; w.tgt = UPC_L1; w.nxt = UPC_L1;
      end
      UPC_L1: begin
        w.emit = 1'b1; w.enable = 1'b1; w.tgt = UPC_L2; w.nxt = UPC_L2;
      end
      UPC_L2: begin
        w.emit = 1'b1; w.last_chk = 1'b1; w.cond = COND_PTR_NZ;
        w.tgt = UPC_H0; w.nxt = UPC_IDLE;
      end
      default: begin
        w.tgt = UPC_IDLE; w.nxt = UPC_IDLE;
      end
    endcase
    return w;
  endfunction

  upc_t upc_r;
  upc_t upc_nxt;
  logic taken;

  assign uw   = rom_word(upc_r);
  assign busy = (upc_r != UPC_IDLE);

  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS: taken = 1'b1;
      COND_START:  taken = flags.start;
      COND_Q_NZ:   taken = flags.q_nz;
      COND_PTR_NZ: taken = flags.ptr_nz;
      default:     taken = 1'b0;
    endcase
    upc_nxt = taken ? uw.tgt : uw.nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UPC_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// ===== rtl/ldnp_dpath.sv =====
// ----------------------------------------------------------------------------
// ldnp_dpath - conversion and byte datapath
// Divide by ten through a reciprocal multiply, digit store, expander bytes.
// ----------------------------------------------------------------------------
module ldnp_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ldnp_pkg::uword_t               uw,
  input  logic                           start,
  input  logic [ldnp_pkg::NUM_W-1:0]     in_value,
  input  logic [ldnp_pkg::ADDR_W-1:0]    disp_addr,
  output ldnp_pkg::dp_flags_t            flags,
  output logic [ldnp_pkg::BYTE_W-1:0]    out_expander_byte,
  output logic [ldnp_pkg::ADDR_W-1:0]    out_target_address,
  output logic                           out_last,
  output logic                           out_strobe
);
  import ldnp_pkg::*;

  logic [NUM_W-1:0]     num_r;
  logic [PROD_W-1:0]    prod_r;
  logic [NIB_W-1:0]     dig_r [DIGITS];
  logic [DIG_IDX_W-1:0] cnt_r;
  logic [DIG_IDX_W-1:0] ptr_r;
  logic [BYTE_W-1:0]    byte_r;
  logic [ADDR_W-1:0]    addr_r;
  logic                 last_r;
  logic                 strobe_r;

  logic [QUO_W-1:0]     quo;
  logic [NUM_W-1:0]     rem_full;
  logic [NIB_W-1:0]     nib;
  logic                 ptr_nz;

  assign quo      = prod_r[PROD_W-1:RECIP_SHIFT];
  assign rem_full = num_r - NUM_W'({quo, 3'b000}) - NUM_W'({quo, 1'b0});
  assign ptr_nz   = (ptr_r != '0);
  assign nib      = uw.nib_hi ? ASCII_DIG_HI : dig_r[ptr_r];

  assign flags = '{start: start, q_nz: (quo != '0), ptr_nz: ptr_nz};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      ptr_r    <= '0;
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      if (uw.load && start) begin
        num_r <= in_value;
        cnt_r <= '0;
      end
      if (uw.mul) begin
        prod_r <= PROD_W'(num_r) * PROD_W'(RECIP_10);
      end
      if (uw.div) begin
        dig_r[cnt_r] <= rem_full[NIB_W-1:0];
        num_r        <= NUM_W'(quo);
        cnt_r        <= cnt_r + 1'b1;
        ptr_r        <= cnt_r;
      end
      if (uw.emit && uw.last_chk && ptr_nz) begin
        ptr_r <= ptr_r - 1'b1;
      end
      strobe_r <= uw.emit;
      last_r   <= uw.emit && uw.last_chk && !ptr_nz;
      if (uw.emit) begin
        byte_r <= {nib, BACKLIGHT_ON, uw.enable, RW_WRITE, RS_DATA};
        addr_r <= disp_addr;
      end
    end
  end

  assign out_expander_byte  = byte_r;
  assign out_target_address = addr_r;
  assign out_last           = last_r;
  assign out_strobe         = strobe_r;

endmodule

// ===== rtl/lcd_decimal_number_printer.sv =====
// ----------------------------------------------------------------------------
// lcd_decimal_number_printer - 16-bit number to HD44780 4-bit expander bytes
// Prints a number in decimal, no leading zeros, as expander bytes for an LCD
// behind an I2C port expander: three bytes per nibble, two nibbles per digit.
// ----------------------------------------------------------------------------
//  channel | ports                                             | handshake
//  --------+---------------------------------------------------+----------------
//  input   | in_value[15:0]                                    | start & !busy
//  result  | out_expander_byte, out_target_address, out_last   | out_strobe
//  config  | cfg_display_address[6:0]                          | cfg_valid&ready
//
//  A number with d digits (1..5) is first converted after the accepting
//  edge (one multiply step and one digit step per digit on the shared
//  reciprocal multiplier) and then sent out, one word per cycle from the
//  microcode program, through the output register.
//  busy falls in the cycle the last word is on the ports; a new number can
//  be taken in that same cycle.
//  rst_n is synchronous; it parks the sequencer at its idle step and sets
//  the display address to 39. The receiver cannot stall; each word is valid
//  for exactly the one cycle that out_strobe marks.
// ----------------------------------------------------------------------------
module lcd_decimal_number_printer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ldnp_pkg::NUM_W-1:0]  in_value,
  output logic [ldnp_pkg::BYTE_W-1:0] out_expander_byte,
  output logic [ldnp_pkg::ADDR_W-1:0] out_target_address,
  output logic                        out_last,
  output logic                        out_strobe,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ldnp_pkg::ADDR_W-1:0] cfg_display_address
);
  import ldnp_pkg::*;

  logic [ADDR_W-1:0] disp_addr_r;
  uword_t            uw;
  dp_flags_t         flags;

  // Configuration: always ready, writes land in the address register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_addr_r <= ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      disp_addr_r <= cfg_display_address;
    end
  end

  // Program sequencer: holds at idle until start, then runs conversion
  // and output microcode
  ldnp_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .uw    (uw),
    .busy  (busy)
  );

  // Datapath: digit split, digit store, byte formatting and output registers
  ldnp_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .uw                 (uw),
    .start              (start),
    .in_value           (in_value),
    .disp_addr          (disp_addr_r),
    .flags              (flags),
    .out_expander_byte  (out_expander_byte),
    .out_target_address (out_target_address),
    .out_last           (out_last),
    .out_strobe         (out_strobe)
  );

  // A word only ever follows a cycle of the program running
  a_strobe_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("word emitted while sequencer idle");

  // An accepted number starts the program
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted number did not start sequencer");

  // The last flag rides on a real word
  a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_strobe)
    else $error("last without strobe");

  // After the final word there is a gap before the next number's words
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |=> !out_strobe)
    else $error("word directly after last");

  // Sequence ends with the program back at idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> !busy)
    else $error("last word while program still running");

endmodule

// ===== test/lcd_decimal_number_printer_test.sv =====
// ----------------------------------------------------------------------------
// lcd_decimal_number_printer_test - self-checking bench for the LCD printer
// Sends 16-bit numbers through the start/busy port and rebuilds the expected
// expander byte stream (three bytes per nibble, two nibbles per digit, no
// leading zeros) in a scoreboard. Each strobed output word is checked
// against the oldest expected word. The display address is rewritten
// between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module lcd_decimal_number_printer_test;

  import ldnp_pkg::*;

  // Expected output word: what one out_strobe cycle must carry
  typedef struct packed {
    logic [BYTE_W-1:0] lcd_byte;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } lcd_word_t;

  localparam logic [BYTE_W-1:0] ENABLE_MASK = 8'h04;
  localparam logic [BYTE_W-1:0] CHAR_ZERO   = "0";
  localparam int                CYCLE_LIMIT = 200000;
  localparam int                MAX_REPORTS = 10;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic [NUM_W-1:0]    in_value = '0;
  logic                cfg_valid = 1'b0;
  logic [ADDR_W-1:0]   cfg_display_address = '0;
  logic                busy;
  logic [BYTE_W-1:0]   out_expander_byte;
  logic [ADDR_W-1:0]   out_target_address;
  logic                out_last;
  logic                out_strobe;
  logic                cfg_ready;

  // Scoreboard and bookkeeping
  lcd_word_t           lcd_words_due[$];
  logic [ADDR_W-1:0]   display_addr_now = ADDR_RESET;
  int                  error_count = 0;
  int                  numbers_sent = 0;
  int                  words_checked = 0;
  int                  addr_writes = 0;
  int                  cycle_count = 0;
  bit                  gaps_off = 1'b0;

  lcd_decimal_number_printer DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_value           (in_value),
    .out_expander_byte  (out_expander_byte),
    .out_target_address (out_target_address),
    .out_last           (out_last),
    .out_strobe         (out_strobe),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_display_address(cfg_display_address)
  );

  always #2 clk = ~clk;

  // Hard stop in case the block hangs or never drains
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycle_count,
               lcd_words_due.size());
      $display("lcd_decimal_number_printer_test NOT OK");
      $finish;
    end
  end

  // Push the three bytes of one nibble: enable low, pulse high, back low
  function automatic void queue_nibble(logic [NIB_W-1:0] nib, logic [ADDR_W-1:0] addr);
    logic [BYTE_W-1:0] base;
    base = {nib, BACKLIGHT_ON, 1'b0, RW_WRITE, RS_DATA};
    lcd_words_due.push_back('{base, addr, 1'b0});
    lcd_words_due.push_back('{base | ENABLE_MASK, addr, 1'b0});
    lcd_words_due.push_back('{base & ~ENABLE_MASK, addr, 1'b0});
  endfunction

  // Work out the full byte stream for one number and queue it
  function automatic void predict_lcd_bytes(logic [NUM_W-1:0] number);
    logic [BYTE_W-1:0] chars [DIGITS];
    int                n_chars;
    int                rest;
    lcd_word_t         tail;
    n_chars = 0;
    rest = number;
    // Peel digits least significant first; zero still yields one digit
    do begin
      chars[n_chars] = CHAR_ZERO + BYTE_W'(rest % 10);
      n_chars++;
      rest = rest / 10;
    end while (rest != 0);
    for (int i = n_chars - 1; i >= 0; i--) begin
      queue_nibble(chars[i][7:4], display_addr_now);
      queue_nibble(chars[i][3:0], display_addr_now);
    end
    // Flag the final byte of the sequence
    tail = lcd_words_due.pop_back();
    tail.last = 1'b1;
    lcd_words_due.push_back(tail);
  endfunction

  // Mostly short gaps, now and then a long one; none while gaps are off
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (gaps_off || roll < 40) begin
      return 0;
    end
    if (roll < 90) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 10);
  endfunction

  // Offer one number and hold it until the block takes it. Start stays
  // high across a zero gap so back-to-back numbers are never dropped and
  // raised in the same step.
  task automatic send_number(logic [NUM_W-1:0] number);
    int gap;
    in_value <= number;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    predict_lcd_bytes(number);
    numbers_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and wait until every expected word has come out
  task automatic wait_idle();
    start <= 1'b0;
    while (lcd_words_due.size() != 0) @(posedge clk);
    // then catch any stray word before returning
    repeat (3) @(posedge clk);
  endtask

  // Write the display address; only called with the block idle
  task automatic write_display_addr(logic [ADDR_W-1:0] addr);
    cfg_display_address <= addr;
    cfg_valid           <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid        <= 1'b0;
    display_addr_now = addr;
    addr_writes++;
  endtask

  // Check every strobed word against the oldest expected one
  always @(posedge clk) begin : word_check
    lcd_word_t want;
    if (rst_n && out_strobe) begin
      words_checked++;
      if (lcd_words_due.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("unexpected word: byte %02h addr %02h last %0b", out_expander_byte,
                   out_target_address, out_last);
        end
      end else begin
        want = lcd_words_due.pop_front();
        if (out_expander_byte !== want.lcd_byte || out_target_address !== want.addr ||
            out_last !== want.last) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("word mismatch: expected byte %02h addr %02h last %0b",
                     want.lcd_byte, want.addr, want.last);
            $display("               got byte %02h addr %02h last %0b",
                     out_expander_byte, out_target_address, out_last);
          end
        end
      end
    end
  end

  // Reset address 39: each digit count, digit extremes and zero
  task automatic test_reset_address();
    send_number(16'd0);
    send_number(16'd9);
    send_number(16'd10);
    send_number(16'd99);
    send_number(16'd100);
    send_number(16'd999);
    send_number(16'd1000);
    send_number(16'd9999);
    send_number(16'd10000);
    send_number(16'd65535);
    send_number(16'd12345);
    send_number(16'd1);
    wait_idle();
  endtask

  // Address extremes and alternating patterns
  task automatic test_address_extremes();
    write_display_addr(7'd0);
    send_number(16'd0);
    send_number(16'd50505);
    wait_idle();
    write_display_addr(7'd127);
    send_number(16'd65535);
    send_number(16'd7);
    wait_idle();
    write_display_addr(7'h55);
    send_number(16'h8000);
    wait_idle();
    write_display_addr(7'h2A);
    send_number(16'h7FFF);
    wait_idle();
  endtask

  // Random numbers in phases, a fresh address for each, no gaps in the third
  task automatic test_random_numbers();
    int               n_digits;
    int               lo;
    int               hi;
    logic [NUM_W-1:0] number;
    for (int phase = 0; phase < 4; phase++) begin
      write_display_addr(ADDR_W'($urandom_range(127)));
      gaps_off = (phase == 2);
      for (int i = 0; i < 25; i++) begin
        if ($urandom_range(9) < 7) begin
          // spread over digit counts so short and long numbers both show up
          n_digits = $urandom_range(5, 1);
          lo = (n_digits == 1) ? 0 : 10 ** (n_digits - 1);
          hi = (n_digits == 5) ? 65535 : 10 ** n_digits - 1;
          number = NUM_W'($urandom_range(hi, lo));
        end else begin
          number = NUM_W'($urandom);
        end
        send_number(number);
      end
      wait_idle();
    end
    gaps_off = 1'b0;
  endtask

  initial begin
    // hold reset, release on an edge
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_address();
    test_address_extremes();
    test_random_numbers();
    // put the reset value back for a last check
    write_display_addr(ADDR_RESET);
    send_number(16'd42);
    wait_idle();

    error_count += lcd_words_due.size();
    $display("covered %0d numbers, %0d expander words, %0d address writes",
             numbers_sent, words_checked, addr_writes);
    if (error_count == 0) begin
      $display("lcd_decimal_number_printer_test OK");
    end else begin
      $display("%0d errors", error_count);
      $display("lcd_decimal_number_printer_test NOT OK");
    end
    $finish;
  end

endmodule
